[hdl/spfm_pkg.sv]
// Shared types and constants for the sensor packet fault monitor.
package spfm_pkg;

  // Number of sensor axes handled per beat
  localparam int unsigned AxisCount = 3;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE_SELECT    = 3'd0;
  localparam logic [2:0] REG_SWITCHOVER     = 3'd1;
  localparam logic [2:0] REG_JERK_LIMIT     = 3'd2;
  localparam logic [2:0] REG_ABS_LIMIT      = 3'd3;
  localparam logic [2:0] REG_PACKET_PERSIST = 3'd4;
  localparam logic [2:0] REG_AXIS_PERSIST   = 3'd5;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 15;

  // Mode codes
  localparam logic [1:0] MODE_OTHER = 2'd0;
  localparam logic [1:0] MODE_11_44 = 2'd1;
  localparam logic [1:0] MODE_33    = 2'd2;

  // Register reset values
  localparam logic [1:0]  MODE_SELECT_RST    = MODE_11_44;
  localparam logic        SWITCHOVER_RST     = 1'b0;
  localparam logic [14:0] JERK_LIMIT_RST     = 15'd801;
  localparam logic [14:0] ABS_LIMIT_RST      = 15'd10240;
  localparam logic [7:0]  PACKET_PERSIST_RST = 8'd20;
  localparam logic [7:0]  AXIS_PERSIST_RST   = 8'd10;

  // Overall status bits
  localparam logic [11:0] PKT_ALL_FAIL = 12'h0DE0;
  localparam logic [AxisCount-1:0][11:0] AXIS_STATUS_BIT = {12'h0800, 12'h0400, 12'h0100};

  // Saturation point of the persistence counters
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  mode_select;
    logic        switchover;
    logic [14:0] jerk_limit;
    logic [14:0] abs_limit;
    logic [7:0]  packet_persist;
    logic [7:0]  axis_persist;
  } cfg_t;

  // Per-beat control into one axis
  typedef struct packed {
    logic m1;
    logic m2;
    logic bad;
    logic hold_abs;
  } axis_ctl_t;

  // Per-beat status out of one axis
  typedef struct packed {
    logic rate_fail;
    logic abs_over;
    logic abs_latch;
    logic subst;
    logic persist_hit;
  } axis_stat_t;

endpackage

[hdl/spfm_if.sv]
// Stream interfaces for sensor beats in and result beats out.
interface spfm_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic                   timeout_seen;
  logic                   header_ok;
  logic                   checksum_ok;
  logic                   payload_ok;
  logic [SAMPLE_BITS-1:0] sample_x;
  logic [SAMPLE_BITS-1:0] sample_y;
  logic [SAMPLE_BITS-1:0] sample_z;

  modport source (output valid, timeout_seen, header_ok, checksum_ok, payload_ok,
                  sample_x, sample_y, sample_z, input ready);
  modport sink (input valid, timeout_seen, header_ok, checksum_ok, payload_ok,
                sample_x, sample_y, sample_z, output ready);
endinterface

interface spfm_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] used_x;
  logic [SAMPLE_BITS-1:0] used_y;
  logic [SAMPLE_BITS-1:0] used_z;
  logic                   packet_fail;
  logic [6:0]             inter_status;
  logic [11:0]            fault_status;
  logic                   sticky_flag;
  logic [2:0]             sys1_fail_bits;
  logic [2:0]             sys2_fail_bits;
  logic [2:0]             rate_fail_bits;
  logic [2:0]             abs_fail_bits;

  modport source (output valid, used_x, used_y, used_z, packet_fail, inter_status,
                  fault_status, sticky_flag, sys1_fail_bits, sys2_fail_bits,
                  rate_fail_bits, abs_fail_bits, input ready);
  modport sink (input valid, used_x, used_y, used_z, packet_fail, inter_status,
                fault_status, sticky_flag, sys1_fail_bits, sys2_fail_bits,
                rate_fail_bits, abs_fail_bits, output ready);
endinterface

[hdl/sensor_packet_fault_monitor.sv]
// Top level of the sensor packet fault monitor: packet checks, axes, result register.
//
// One sensor beat is accepted per clock cycle and its result beat appears in the
// output register on the next cycle. All checks for a beat are done in one pass of
// logic between the input port and that register, with the monitor state updated
// at the same edge, so beats may follow each other every cycle. Input ready is held
// low only while the result register is full and the sink is not taking it.
// Configuration writes take effect at the edge of the write enable.
module sensor_packet_fault_monitor #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [spfm_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [spfm_pkg::CfgDataBits-1:0]      cfg_wdata_i,
  spfm_in_if.sink                               in_i,
  spfm_out_if.source                            out_o
);

  localparam int unsigned NA = spfm_pkg::AxisCount;

  spfm_pkg::cfg_t cfg_q;

  logic [7:0]    pkt_cnt_q, pkt_cnt_d, pkt_inc;
  logic [11:0]   overall_q, overall_d;
  logic [NA-1:0] sys1_q, sys1_d, sys2_q, sys2_d;
  logic          subst_q, subst_d;

  logic          step, m1, m2, bad, pkt_hit;
  logic [SAMPLE_BITS-1:0] smp  [NA];
  logic [SAMPLE_BITS-1:0] used [NA];
  spfm_pkg::axis_stat_t   stat [NA];
  logic [NA-1:0] rate_bits, abs_over_bits, latch_bits, subst_bits, hit_bits;
  logic [11:0]   axis_status;

  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] used_x_q, used_y_q, used_z_q;
  logic                   pkt_fail_q;
  logic [6:0]             inter_q;
  logic [NA-1:0]          rate_q, abs_q;

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_select    <= spfm_pkg::MODE_SELECT_RST;
      cfg_q.switchover     <= spfm_pkg::SWITCHOVER_RST;
      cfg_q.jerk_limit     <= spfm_pkg::JERK_LIMIT_RST;
      cfg_q.abs_limit      <= spfm_pkg::ABS_LIMIT_RST;
      cfg_q.packet_persist <= spfm_pkg::PACKET_PERSIST_RST;
      cfg_q.axis_persist   <= spfm_pkg::AXIS_PERSIST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spfm_pkg::REG_MODE_SELECT:    cfg_q.mode_select    <= cfg_wdata_i[1:0];
        spfm_pkg::REG_SWITCHOVER:     cfg_q.switchover     <= cfg_wdata_i[0];
        spfm_pkg::REG_JERK_LIMIT:     cfg_q.jerk_limit     <= cfg_wdata_i[14:0];
        spfm_pkg::REG_ABS_LIMIT:      cfg_q.abs_limit      <= cfg_wdata_i[14:0];
        spfm_pkg::REG_PACKET_PERSIST: cfg_q.packet_persist <= cfg_wdata_i[7:0];
        spfm_pkg::REG_AXIS_PERSIST:   cfg_q.axis_persist   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Accept a beat whenever the result register can take its result
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign step       = in_i.valid && in_i.ready;

  // Packet health check
  assign m1  = cfg_q.mode_select == spfm_pkg::MODE_11_44;
  assign m2  = cfg_q.mode_select == spfm_pkg::MODE_33;
  assign bad = (in_i.timeout_seen || !in_i.header_ok || !in_i.checksum_ok ||
                !in_i.payload_ok) && m1;
  assign pkt_inc   = (pkt_cnt_q == spfm_pkg::COUNT_MAX) ? pkt_cnt_q : pkt_cnt_q + 8'd1;
  assign pkt_hit   = bad && (pkt_inc >= cfg_q.packet_persist);
  assign pkt_cnt_d = bad ? pkt_inc :
                     ((pkt_cnt_q < cfg_q.packet_persist) ? 8'd0 : pkt_cnt_q);

  assign smp[0] = in_i.sample_x;
  assign smp[1] = in_i.sample_y;
  assign smp[2] = in_i.sample_z;

  // Per-axis checks
  for (genvar g = 0; g < NA; g++) begin : g_axis
    spfm_pkg::axis_ctl_t ctl;
    assign ctl.m1       = m1;
    assign ctl.m2       = m2;
    assign ctl.bad      = bad;
    assign ctl.hold_abs = (g == 0) ? cfg_q.switchover : 1'b0;

    spfm_axis #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_axis (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .step_i   (step),
      .cfg_i    (cfg_q),
      .ctl_i    (ctl),
      .sample_i (smp[g]),
      .used_o   (used[g]),
      .stat_o   (stat[g])
    );

    assign rate_bits[g]     = stat[g].rate_fail;
    assign abs_over_bits[g] = stat[g].abs_over;
    assign latch_bits[g]    = stat[g].abs_latch;
    assign subst_bits[g]    = stat[g].subst;
    assign hit_bits[g]      = stat[g].persist_hit;
  end

  // Merge sticky status
  always_comb begin
    axis_status = '0;
    for (int i = 0; i < NA; i++) begin
      if (hit_bits[i]) begin
        axis_status = axis_status | spfm_pkg::AXIS_STATUS_BIT[i];
      end
    end
  end

  assign overall_d = overall_q | axis_status | (pkt_hit ? spfm_pkg::PKT_ALL_FAIL : 12'h000);
  assign sys1_d    = sys1_q | hit_bits | {NA{pkt_hit}};
  assign sys2_d    = sys2_q | {NA{pkt_hit}};
  assign subst_d   = subst_q | bad | (|subst_bits);

  // Commit monitor state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_cnt_q <= '0;
      overall_q <= '0;
      sys1_q    <= '0;
      sys2_q    <= '0;
      subst_q   <= 1'b0;
    end else if (step) begin
      pkt_cnt_q <= pkt_cnt_d;
      overall_q <= overall_d;
      sys1_q    <= sys1_d;
      sys2_q    <= sys2_d;
      subst_q   <= subst_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      used_x_q   <= used[0];
      used_y_q   <= used[1];
      used_z_q   <= used[2];
      pkt_fail_q <= bad;
      inter_q    <= {rate_bits, 1'b0, abs_over_bits};
      rate_q     <= rate_bits;
      abs_q      <= latch_bits;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.used_x         = used_x_q;
  assign out_o.used_y         = used_y_q;
  assign out_o.used_z         = used_z_q;
  assign out_o.packet_fail    = pkt_fail_q;
  assign out_o.inter_status   = inter_q;
  assign out_o.fault_status   = overall_q;
  assign out_o.sticky_flag    = subst_q;
  assign out_o.sys1_fail_bits = sys1_q;
  assign out_o.sys2_fail_bits = sys2_q;
  assign out_o.rate_fail_bits = rate_q;
  assign out_o.abs_fail_bits  = abs_q;

  // Sticky fail latches never clear
  a_sys1_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((sys1_q & $past(sys1_q)) == $past(sys1_q)))
    else $error("system-1 fail latch cleared");

  // System-2 fails only come with all system-1 fails
  a_sys2_implies_sys1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sys2_q != '0) |-> (sys1_q == {NA{1'b1}}))
    else $error("system-2 fail without full system-1 fail");

  // A failed packet always shows the substitution flag
  a_pkt_fail_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && pkt_fail_q) |-> subst_q)
    else $error("packet fail without substitution flag");

  // Axis status bits are backed by their fail latches
  a_axis_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!overall_q[8] || sys1_q[0]) && (!overall_q[10] || sys1_q[1]) &&
    (!overall_q[11] || sys1_q[2]))
    else $error("axis status bit without fail latch");

endmodule

[hdl/spfm_axis.sv]
// One axis: substitution, rate and absolute checks, and persistence counter.
module spfm_axis #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  spfm_pkg::cfg_t         cfg_i,
  input  spfm_pkg::axis_ctl_t    ctl_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [SAMPLE_BITS-1:0] used_o,
  output spfm_pkg::axis_stat_t   stat_o
);

  localparam int unsigned CW = ((SAMPLE_BITS + 1) > 15 ? (SAMPLE_BITS + 1) : 15) + 1;

  logic [SAMPLE_BITS-1:0] last_q, last_d;
  logic [7:0]             cnt_q, cnt_d;
  logic                   latch_q, latch_d;

  logic [SAMPLE_BITS-1:0] cand;
  logic signed [CW-1:0]   cur_ext, old_ext, diff, mag, jerk_ext, lim_ext;
  logic                   active, abs_over, subst;
  logic [7:0]             cnt_inc;

  // Take the held sample on a bad packet
  assign cand    = ctl_i.bad ? last_q : sample_i;
  assign cur_ext = CW'($signed(cand));
  assign old_ext = CW'($signed(last_q));
  assign diff    = cur_ext - old_ext;
  assign mag     = (diff < 0) ? -diff : diff;
  assign jerk_ext = CW'($signed({1'b0, cfg_i.jerk_limit}));
  assign lim_ext  = CW'($signed({1'b0, cfg_i.abs_limit}));

  assign active   = ctl_i.m1 || ctl_i.m2;
  assign abs_over = ((cur_ext > lim_ext) || (cur_ext < -lim_ext)) && active;
  assign cnt_inc  = (cnt_q == spfm_pkg::COUNT_MAX) ? cnt_q : cnt_q + 8'd1;

  // Update latch, decide substitution and advance the counter
  always_comb begin
    if (abs_over) begin
      latch_d = ctl_i.hold_abs ? latch_q : 1'b1;
    end else begin
      latch_d = 1'b0;
    end
    subst = latch_d && !ctl_i.bad && active;
    if (subst) begin
      used_o = last_q;
      last_d = last_q;
      cnt_d  = cnt_inc;
    end else begin
      used_o = cand;
      last_d = cand;
      cnt_d  = (cnt_q < cfg_i.axis_persist) ? 8'd0 : cnt_q;
    end
  end

  assign stat_o.rate_fail   = mag > jerk_ext;
  assign stat_o.abs_over    = abs_over;
  assign stat_o.abs_latch   = latch_d;
  assign stat_o.subst       = subst;
  assign stat_o.persist_hit = subst && (cnt_inc >= cfg_i.axis_persist);

  // Commit axis state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      cnt_q   <= '0;
      latch_q <= 1'b0;
    end else if (step_i) begin
      last_q  <= last_d;
      cnt_q   <= cnt_d;
      latch_q <= latch_d;
    end
  end

endmodule

[sim/testbench.sv]
// Self-checking testbench for the sensor packet fault monitor: directed table, then random phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SampleBits = 16;
  localparam int QuietLimit = 2000;
  localparam int LongHold   = 80;
  localparam int ReportMax  = 10;

  // Mode code the block treats like the other mode
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Packet-health flag patterns: {timeout_seen, header_ok, checksum_ok, payload_ok}
  localparam logic [3:0] FLAGS_GOOD        = 4'b0111;
  localparam logic [3:0] FLAGS_TIMEOUT     = 4'b1111;
  localparam logic [3:0] FLAGS_NO_HEADER   = 4'b0011;
  localparam logic [3:0] FLAGS_NO_CHECKSUM = 4'b0101;
  localparam logic [3:0] FLAGS_NO_PAYLOAD  = 4'b0110;
  localparam logic [3:0] FLAGS_ALL_BAD     = 4'b1000;

  typedef logic [spfm_pkg::AxisCount-1:0][SampleBits-1:0] axis_samples_t;

  typedef struct packed {
    logic          timeout_seen;
    logic          header_ok;
    logic          checksum_ok;
    logic          payload_ok;
    axis_samples_t sample;
  } sensor_beat_t;

  typedef struct packed {
    axis_samples_t used;
    logic          packet_fail;
    logic [6:0]    inter_status;
    logic [11:0]   fault_status;
    logic          sticky_flag;
    logic [2:0]    sys1_fail_bits;
    logic [2:0]    sys2_fail_bits;
    logic [2:0]    rate_fail_bits;
    logic [2:0]    abs_fail_bits;
  } monitor_result_t;

  typedef struct packed {
    logic [3:0]      flags;
    axis_samples_t   sample;
    logic            typed;
    monitor_result_t outcome;
  } probe_row_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        sw;
    logic [14:0] jerk;
    logic [14:0] abs_lim;
    logic [7:0]  pkt_persist;
    logic [7:0]  axis_persist;
    logic [15:0] beats;
    logic [7:0]  bad_pct;
  } phase_t;

  // Directed beats under the reset settings; the first three carry their result
  localparam int NumProbes = 15;
  localparam probe_row_t Probes [NumProbes] = '{
    '{FLAGS_GOOD,        48'h0000_0000_0000, 1'b1,
      '{48'h0, 1'b0, 7'h00, 12'h000, 1'b0, 3'b000, 3'b000, 3'b000, 3'b000}},
    '{FLAGS_TIMEOUT,     48'h7FFF_7FFF_7FFF, 1'b1,
      '{48'h0, 1'b1, 7'h00, 12'h000, 1'b1, 3'b000, 3'b000, 3'b000, 3'b000}},
    '{FLAGS_GOOD,        48'h0000_D800_2800, 1'b1,
      '{48'h0000_D800_2800, 1'b0, 7'h30, 12'h000, 1'b1, 3'b000, 3'b000, 3'b011, 3'b000}},
    '{FLAGS_GOOD,        48'h0000_D7FF_2801, 1'b0, '0},
    '{FLAGS_GOOD,        48'h7FFF_7FFF_7FFF, 1'b0, '0},
    '{FLAGS_GOOD,        48'h8000_8000_8000, 1'b0, '0},
    '{FLAGS_NO_HEADER,   48'h1234_8000_7FFF, 1'b0, '0},
    '{FLAGS_NO_CHECKSUM, 48'h0001_FFFF_0000, 1'b0, '0},
    '{FLAGS_NO_PAYLOAD,  48'hAAAA_5555_FFFF, 1'b0, '0},
    '{FLAGS_ALL_BAD,     48'h5555_AAAA_8000, 1'b0, '0},
    '{FLAGS_GOOD,        48'h0000_0000_0000, 1'b0, '0},
    '{FLAGS_GOOD,        48'h0000_0000_0321, 1'b0, '0},
    '{FLAGS_GOOD,        48'h0000_0000_0643, 1'b0, '0},
    '{FLAGS_GOOD,        48'hFFFF_0001_FCDF, 1'b0, '0},
    '{FLAGS_GOOD,        48'h5555_AAAA_0000, 1'b0, '0}
  };

  // Register settings per random phase, mildest first so sticky bits latch late
  localparam int NumPhases = 9;
  localparam phase_t Phases [NumPhases] = '{
    '{spfm_pkg::MODE_SELECT_RST, spfm_pkg::SWITCHOVER_RST, spfm_pkg::JERK_LIMIT_RST,
      spfm_pkg::ABS_LIMIT_RST, spfm_pkg::PACKET_PERSIST_RST, spfm_pkg::AXIS_PERSIST_RST,
      16'd60, 8'd10},
    '{spfm_pkg::MODE_33,    1'b0, 15'd32767, 15'd32767, 8'd255, 8'd255, 16'd60,  8'd30},
    '{spfm_pkg::MODE_OTHER, 1'b1, 15'd500,   15'd8000,  8'd5,   8'd5,   16'd60,  8'd30},
    '{MODE_SPARE,           1'b0, 15'd300,   15'd4000,  8'd3,   8'd3,   16'd60,  8'd30},
    '{spfm_pkg::MODE_33,    1'b1, 15'd200,   15'd12000, 8'd2,   8'd4,   16'd60,  8'd20},
    '{spfm_pkg::MODE_11_44, 1'b1, 15'd0,     15'd0,     8'd1,   8'd1,   16'd60,  8'd20},
    '{spfm_pkg::MODE_11_44, 1'b0, 15'd1000,  15'd6000,  8'd0,   8'd0,   16'd60,  8'd40},
    '{spfm_pkg::MODE_11_44, 1'b0, 15'd2000,  15'd16384, 8'd1,   8'd1,   16'd200, 8'd90},
    '{spfm_pkg::MODE_33,    1'b1, 15'd800,   15'd0,     8'd20,  8'd1,   16'd170, 8'd10}
  };
  localparam int HoldPhase  = 1;
  localparam int PausePhase = 3;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [spfm_pkg::CfgIdxBits-1:0]  cfg_idx;
  logic [spfm_pkg::CfgDataBits-1:0] cfg_wdata;

  spfm_in_if  #(.SAMPLE_BITS(SampleBits)) sensor_bus ();
  spfm_out_if #(.SAMPLE_BITS(SampleBits)) result_bus ();

  sensor_packet_fault_monitor #(
    .SAMPLE_BITS(SampleBits)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (sensor_bus),
    .out_o      (result_bus)
  );

  always #5 clk = ~clk;

  // Monitor state as the block should hold it
  spfm_pkg::cfg_t mon_cfg;
  axis_samples_t  lg_sample;
  logic [7:0]     bad_run;
  logic [7:0]     axis_run [spfm_pkg::AxisCount];
  logic [2:0]     abs_hold;
  logic [6:0]     inter_bits;
  logic [11:0]    overall_bits;
  logic [2:0]     sys1_bits;
  logic [2:0]     sys2_bits;
  logic           subst_seen;

  monitor_result_t pending [$];
  int  mismatches;
  int  results_seen;
  int  quiet;
  bit  feed_burst;
  bit  sink_burst;
  bit  sink_hold_req;
  bit  sink_holding;

  // Work out the result beat of one sensor beat and advance the monitor state
  function automatic monitor_result_t predict_monitor(input sensor_beat_t beat);
    monitor_result_t r;
    logic m1;
    logic m2;
    logic bad;
    int   cur_v;
    int   old_v;
    int   diff;
    int   lim;
    m1  = (mon_cfg.mode_select == spfm_pkg::MODE_11_44);
    m2  = (mon_cfg.mode_select == spfm_pkg::MODE_33);
    bad = m1 && (beat.timeout_seen || !beat.header_ok || !beat.checksum_ok ||
                 !beat.payload_ok);
    r = '0;
    r.used = beat.sample;

    // Substitute the whole packet and bump the bad-packet run
    if (bad) begin
      r.used = lg_sample;
      if (bad_run != spfm_pkg::COUNT_MAX) bad_run = bad_run + 8'd1;
      r.packet_fail = 1'b1;
      subst_seen = 1'b1;
      if (bad_run >= mon_cfg.packet_persist) begin
        overall_bits |= spfm_pkg::PKT_ALL_FAIL;
        sys1_bits = '1;
        sys2_bits = '1;
      end
    end else if (bad_run < mon_cfg.packet_persist) begin
      bad_run = '0;
    end

    for (int a = 0; a < spfm_pkg::AxisCount; a++) begin
      cur_v = $signed(r.used[a]);
      old_v = $signed(lg_sample[a]);
      diff  = cur_v - old_v;
      if (diff < 0) diff = -diff;
      lim = int'(mon_cfg.abs_limit);

      // Rate check against the last good sample
      if (diff > int'(mon_cfg.jerk_limit)) begin
        inter_bits[a+4] = 1'b1;
        r.rate_fail_bits[a] = 1'b1;
      end else begin
        inter_bits[a+4] = 1'b0;
      end

      // Absolute check; axis 0 latch holds under switchover
      if ((cur_v > lim || cur_v < -lim) && (m1 || m2)) begin
        inter_bits[a] = 1'b1;
        if (a != 0 || !mon_cfg.switchover) abs_hold[a] = 1'b1;
      end else begin
        abs_hold[a] = 1'b0;
        inter_bits[a] = 1'b0;
      end

      // Restore the axis or accept its sample
      if (abs_hold[a] && ((!r.packet_fail && m1) || m2)) begin
        subst_seen = 1'b1;
        r.used[a] = lg_sample[a];
        if (axis_run[a] != spfm_pkg::COUNT_MAX) axis_run[a] = axis_run[a] + 8'd1;
        if (axis_run[a] >= mon_cfg.axis_persist) begin
          overall_bits |= spfm_pkg::AXIS_STATUS_BIT[a];
          sys1_bits[a] = 1'b1;
        end
      end else begin
        lg_sample[a] = r.used[a];
        if (axis_run[a] < mon_cfg.axis_persist) axis_run[a] = '0;
      end
    end

    r.inter_status   = inter_bits;
    r.fault_status   = overall_bits;
    r.sticky_flag    = subst_seen;
    r.sys1_fail_bits = sys1_bits;
    r.sys2_fail_bits = sys2_bits;
    r.abs_fail_bits  = abs_hold;
    return r;
  endfunction

  // Draw one sample: mostly near the last good value, some at the limit, some wild
  function automatic logic [SampleBits-1:0] pick_sample(input int a);
    int span;
    int base;
    int v;
    base = $signed(lg_sample[a]);
    span = (mon_cfg.jerk_limit > 15'd2000) ? 2000 : int'(mon_cfg.jerk_limit) + 16;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = base + int'($urandom_range(0, 2 * span)) - span;
      5, 6: begin
        v = int'(mon_cfg.abs_limit) + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      7: begin
        case ($urandom_range(0, 4))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom_range(0, 65535));
    endcase
    return v[SampleBits-1:0];
  endfunction

  function automatic sensor_beat_t random_beat(input int bad_pct);
    sensor_beat_t b;
    logic [3:0] flags;
    int v;
    flags = FLAGS_GOOD;
    if (int'($urandom_range(0, 99)) < bad_pct) begin
      v = int'($urandom_range(0, 14));
      if (v >= int'(FLAGS_GOOD)) v++;
      flags = v[3:0];
    end
    {b.timeout_seen, b.header_ok, b.checksum_ok, b.payload_ok} = flags;
    for (int a = 0; a < spfm_pkg::AxisCount; a++) b.sample[a] = pick_sample(a);
    return b;
  endfunction

  // Offer one beat after a random gap, hold it until taken, then queue its result
  task automatic send_beat(input sensor_beat_t beat, input logic typed,
                           input monitor_result_t typed_result);
    int gap;
    monitor_result_t predicted;
    gap = (feed_burst || sink_hold_req || sink_holding) ? 0 : int'($urandom_range(0, 14));
    if ($urandom_range(0, 23) == 0) feed_burst = !feed_burst;
    if (gap > 0) begin
      sensor_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sensor_bus.valid        <= 1'b1;
    sensor_bus.timeout_seen <= beat.timeout_seen;
    sensor_bus.header_ok    <= beat.header_ok;
    sensor_bus.checksum_ok  <= beat.checksum_ok;
    sensor_bus.payload_ok   <= beat.payload_ok;
    sensor_bus.sample_x     <= beat.sample[0];
    sensor_bus.sample_y     <= beat.sample[1];
    sensor_bus.sample_z     <= beat.sample[2];
    @(posedge clk);
    while (!sensor_bus.ready) @(posedge clk);
    predicted = predict_monitor(beat);
    pending.push_back(typed ? typed_result : predicted);
  endtask

  // Hold off until every queued result beat has come back
  task automatic drain_results();
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [spfm_pkg::CfgIdxBits-1:0] idx,
                           input logic [spfm_pkg::CfgDataBits-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      spfm_pkg::REG_MODE_SELECT:    mon_cfg.mode_select    = data[1:0];
      spfm_pkg::REG_SWITCHOVER:     mon_cfg.switchover     = data[0];
      spfm_pkg::REG_JERK_LIMIT:     mon_cfg.jerk_limit     = data[14:0];
      spfm_pkg::REG_ABS_LIMIT:      mon_cfg.abs_limit      = data[14:0];
      spfm_pkg::REG_PACKET_PERSIST: mon_cfg.packet_persist = data[7:0];
      spfm_pkg::REG_AXIS_PERSIST:   mon_cfg.axis_persist   = data[7:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [SampleBits-1:0] want,
                             input logic [SampleBits-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= ReportMax)
        $display("%0t: result beat %0d %s expected %h got %h",
                 $time, results_seen, name, want, got);
    end
  endtask

  // Compare each result beat with the oldest queued one
  always @(posedge clk) begin
    monitor_result_t want;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("%0t: result beat %0d arrived with nothing queued", $time, results_seen);
      end else begin
        want = pending.pop_front();
        check_field("used_x", want.used[0], result_bus.used_x);
        check_field("used_y", want.used[1], result_bus.used_y);
        check_field("used_z", want.used[2], result_bus.used_z);
        check_field("packet_fail", 16'(want.packet_fail), 16'(result_bus.packet_fail));
        check_field("inter_status", 16'(want.inter_status), 16'(result_bus.inter_status));
        check_field("fault_status", 16'(want.fault_status),
                    16'(result_bus.fault_status));
        check_field("sticky_flag", 16'(want.sticky_flag), 16'(result_bus.sticky_flag));
        check_field("sys1_fail_bits", 16'(want.sys1_fail_bits),
                    16'(result_bus.sys1_fail_bits));
        check_field("sys2_fail_bits", 16'(want.sys2_fail_bits),
                    16'(result_bus.sys2_fail_bits));
        check_field("rate_fail_bits", 16'(want.rate_fail_bits),
                    16'(result_bus.rate_fail_bits));
        check_field("abs_fail_bits", 16'(want.abs_fail_bits),
                    16'(result_bus.abs_fail_bits));
      end
      results_seen++;
    end
  end

  // Drop the run when no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((sensor_bus.valid && sensor_bus.ready) || (result_bus.valid && result_bus.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QuietLimit) begin
        $display("FAIL sensor_packet_fault_monitor");
        $finish;
      end
    end
  end

  // Result sink: stall a random number of cycles per beat, or one long hold on request
  initial begin
    int stall;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        stall = LongHold;
        sink_hold_req = 1'b0;
        sink_holding = 1'b1;
      end else begin
        stall = sink_burst ? 0 : int'($urandom_range(0, 14));
      end
      if ($urandom_range(0, 23) == 0) sink_burst = !sink_burst;
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      sink_holding = 1'b0;
      @(posedge clk);
      while (!(result_bus.valid && result_bus.ready)) @(posedge clk);
    end
  end

  initial begin
    sensor_beat_t beat;
    // Known values on every input from time zero
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_idx                 = '0;
    cfg_wdata               = '0;
    sensor_bus.valid        = 1'b0;
    sensor_bus.timeout_seen = 1'b0;
    sensor_bus.header_ok    = 1'b1;
    sensor_bus.checksum_ok  = 1'b1;
    sensor_bus.payload_ok   = 1'b1;
    sensor_bus.sample_x     = '0;
    sensor_bus.sample_y     = '0;
    sensor_bus.sample_z     = '0;
    result_bus.ready        = 1'b0;

    mon_cfg = '{spfm_pkg::MODE_SELECT_RST, spfm_pkg::SWITCHOVER_RST,
                spfm_pkg::JERK_LIMIT_RST, spfm_pkg::ABS_LIMIT_RST,
                spfm_pkg::PACKET_PERSIST_RST, spfm_pkg::AXIS_PERSIST_RST};
    lg_sample    = '0;
    bad_run      = '0;
    abs_hold     = '0;
    inter_bits   = '0;
    overall_bits = '0;
    sys1_bits    = '0;
    sys2_bits    = '0;
    subst_seen   = 1'b0;
    for (int a = 0; a < spfm_pkg::AxisCount; a++) axis_run[a] = '0;
    mismatches    = 0;
    results_seen  = 0;
    quiet         = 0;
    feed_burst    = 1'b0;
    sink_burst    = 1'b0;
    sink_hold_req = 1'b0;
    sink_holding  = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table under the reset settings
    for (int p = 0; p < NumProbes; p++) begin
      beat = {Probes[p].flags, Probes[p].sample};
      send_beat(beat, Probes[p].typed, Probes[p].outcome);
    end
    sensor_bus.valid <= 1'b0;
    drain_results();

    // Random phases, each under its own register settings
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_reg(spfm_pkg::REG_MODE_SELECT, spfm_pkg::CfgDataBits'(Phases[ph].mode));
      write_reg(spfm_pkg::REG_SWITCHOVER,  spfm_pkg::CfgDataBits'(Phases[ph].sw));
      write_reg(spfm_pkg::REG_JERK_LIMIT,  Phases[ph].jerk);
      write_reg(spfm_pkg::REG_ABS_LIMIT,   Phases[ph].abs_lim);
      write_reg(spfm_pkg::REG_PACKET_PERSIST,
                spfm_pkg::CfgDataBits'(Phases[ph].pkt_persist));
      write_reg(spfm_pkg::REG_AXIS_PERSIST,
                spfm_pkg::CfgDataBits'(Phases[ph].axis_persist));
      cfg_we <= 1'b0;
      for (int n = 0; n < int'(Phases[ph].beats); n++) begin
        // Stall the sink for a long stretch while beats keep coming
        if (ph == HoldPhase && n == 20) sink_hold_req = 1'b1;
        // Let every queued result come back before going on
        if (ph == PausePhase && n == 30) begin
          sensor_bus.valid <= 1'b0;
          drain_results();
        end
        beat = random_beat(int'(Phases[ph].bad_pct));
        send_beat(beat, 1'b0, '0);
      end
      sensor_bus.valid <= 1'b0;
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (pending.size() != 0) begin
      $display("%0d result beats never arrived", pending.size());
      mismatches += pending.size();
    end
    if (mismatches == 0) begin
      $display("PASS sensor_packet_fault_monitor");
    end else begin
      $display("FAIL sensor_packet_fault_monitor");
    end
    $finish;
  end

endmodule
